/* design/ics_pkg.sv */
// Shared types and constants for the input completeness scanner.
// No dependencies; imported by ics_core and input_completeness_scanner.
`default_nettype none

package ics_pkg;

  // Default width of the depth and try/catch counters
  localparam int unsigned COUNT_BITS_DEF = 8;

  // One input transaction: a source byte plus end-of-text flag
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic       complete;
    logic [2:0] reason_code;
  } out_item_t;

  // Reason codes, first match wins
  typedef enum logic [2:0] {
    RSN_COMPLETE   = 3'd0,
    RSN_OPEN_BLOCK = 3'd1,
    RSN_OPEN_STR   = 3'd2,
    RSN_UNBALANCED = 3'd3,
    RSN_TRY_OPEN   = 3'd4
  } reason_t;

  // Lexer mode flags
  typedef struct packed {
    logic slash;  // slash seen outside, comment start pending
    logic star;   // star seen inside block comment
    logic block;  // inside block comment
    logic line;   // inside line comment
    logic esc;    // backslash escape pending in string
    logic str;    // inside string literal
  } mode_t;

  // Current word tracking
  typedef struct packed {
    logic [2:0] len;    // 0 = not in a word, saturates at 7
    logic       catch_ok;
    logic       try_ok;
  } word_t;

  // Character codes
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

endpackage

`default_nettype wire

/* design/ics_core.sv */
// Scanner state and per-character update logic, plus the end-of-text verdict.
// Depends on ics_pkg for item types, mode flags and character codes.
`default_nettype none

module ics_core
  import ics_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  output out_item_t      result
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam word_t WORD_IDLE = '{len: 3'd0, catch_ok: 1'b1, try_ok: 1'b1};

  // Saturating signed counter steps
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v != CNT_MAX) ? v + CNT_ONE : v;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_dec(input logic [COUNT_BITS-1:0] v);
    return (v != CNT_MIN) ? v - CNT_ONE : v;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  // Append a character to the current word, narrowing the keyword matches
  function automatic word_t word_add(input word_t w, input logic [7:0] c);
    word_t r;
    logic  try_hit;
    logic  catch_hit;
    r = w;
    unique case (w.len)
      3'd0:    try_hit = (c == 8'h74);  // t
      3'd1:    try_hit = (c == 8'h72);  // r
      3'd2:    try_hit = (c == 8'h79);  // y
      default: try_hit = 1'b0;
    endcase
    unique case (w.len)
      3'd0:    catch_hit = (c == 8'h63);  // c
      3'd1:    catch_hit = (c == 8'h61);  // a
      3'd2:    catch_hit = (c == 8'h74);  // t
      3'd3:    catch_hit = (c == 8'h63);  // c
      3'd4:    catch_hit = (c == 8'h68);  // h
      default: catch_hit = 1'b0;
    endcase
    r.try_ok   = w.try_ok & try_hit;
    r.catch_ok = w.catch_ok & catch_hit;
    if (w.len != 3'd7) begin
      r.len = w.len + 3'd1;
    end
    return r;
  endfunction

  // Close a word: whole "try" counts up, whole "catch" counts down
  function automatic logic [COUNT_BITS-1:0] word_end(input word_t w,
                                                     input logic [COUNT_BITS-1:0] s);
    logic [COUNT_BITS-1:0] r;
    r = s;
    if (w.len == 3'd3 && w.try_ok) begin
      r = sat_inc(s);
    end else if (w.len == 3'd5 && w.catch_ok) begin
      r = sat_dec(s);
    end
    return r;
  endfunction

  // State registers
  logic [COUNT_BITS-1:0] brace_depth, paren_depth, square_depth, try_surplus;
  mode_t                 mode;
  word_t                 word;

  logic [COUNT_BITS-1:0] brace_depth_next, paren_depth_next, square_depth_next;
  logic [COUNT_BITS-1:0] try_surplus_next, try_final;
  mode_t                 mode_next;
  word_t                 word_next;

  logic [7:0] c;
  logic       more;
  logic       go;
  reason_t    reason;

  assign c    = item.char_code;
  assign more = ~item.last_char;

  // Per-character scan
  always_comb begin
    brace_depth_next  = brace_depth;
    paren_depth_next  = paren_depth;
    square_depth_next = square_depth;
    try_surplus_next  = try_surplus;
    mode_next         = mode;
    word_next         = word;
    go                = 1'b0;

    if (mode.block) begin
      if (mode.star && c == CH_SLASH) begin
        mode_next.block = 1'b0;
        mode_next.star  = 1'b0;
      end else begin
        mode_next.star = (c == CH_STAR);
      end
    end else if (mode.line) begin
      if (c == CH_NEWLINE) begin
        mode_next.line = 1'b0;
      end
    end else if (mode.str) begin
      if (mode.esc) begin
        mode_next.esc = 1'b0;
      end else if (c == CH_BSLASH && more) begin
        mode_next.esc = 1'b1;
      end else if (c == CH_QUOTE) begin
        mode_next.str = 1'b0;
      end
    end else begin
      go = 1'b1;
      // Word in progress: extend it or close it
      if (word.len != 3'd0) begin
        if (is_wordch(c)) begin
          word_next = word_add(word, c);
          go        = 1'b0;
        end else begin
          try_surplus_next = word_end(word, try_surplus);
          word_next        = WORD_IDLE;
        end
      end
      // Pending slash resolves into a comment start or nothing
      if (go && mode.slash) begin
        mode_next.slash = 1'b0;
        if (c == CH_SLASH) begin
          mode_next.line = 1'b1;
          go             = 1'b0;
        end else if (c == CH_STAR) begin
          mode_next.block = 1'b1;
          go              = 1'b0;
        end
      end
      if (go) begin
        priority if (c == CH_QUOTE) begin
          mode_next.str = 1'b1;
        end else if (c == CH_SLASH && more) begin
          mode_next.slash = 1'b1;
        end else if (is_alpha(c)) begin
          word_next = word_add(word_next, c);
        end else begin
          unique case (c)
            CH_LBRACE:  brace_depth_next  = sat_inc(brace_depth);
            CH_RBRACE:  brace_depth_next  = sat_dec(brace_depth);
            CH_LPAREN:  paren_depth_next  = sat_inc(paren_depth);
            CH_RPAREN:  paren_depth_next  = sat_dec(paren_depth);
            CH_LSQUARE: square_depth_next = sat_inc(square_depth);
            CH_RSQUARE: square_depth_next = sat_dec(square_depth);
            default: ;
          endcase
        end
      end
    end
  end

  // Verdict at end of text; an open word still counts
  always_comb begin
    try_final = (word_next.len != 3'd0) ? word_end(word_next, try_surplus_next)
                                        : try_surplus_next;
    priority if (mode_next.block) begin
      reason = RSN_OPEN_BLOCK;
    end else if (mode_next.str) begin
      reason = RSN_OPEN_STR;
    end else if (brace_depth_next != '0 || paren_depth_next != '0 ||
                 square_depth_next != '0) begin
      reason = RSN_UNBALANCED;
    end else if (!try_final[COUNT_BITS-1] && try_final != '0) begin
      reason = RSN_TRY_OPEN;
    end else begin
      reason = RSN_COMPLETE;
    end
    result.complete    = (reason == RSN_COMPLETE);
    result.reason_code = reason;
  end

  // State update; everything returns to reset after the last character
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_char)) begin
      brace_depth  <= '0;
      paren_depth  <= '0;
      square_depth <= '0;
      try_surplus  <= '0;
      mode         <= '0;
      word         <= WORD_IDLE;
    end else if (step) begin
      brace_depth  <= brace_depth_next;
      paren_depth  <= paren_depth_next;
      square_depth <= square_depth_next;
      try_surplus  <= try_surplus_next;
      mode         <= mode_next;
      word         <= word_next;
    end
  end

endmodule

`default_nettype wire

/* design/input_completeness_scanner.sv */
// Input completeness scanner top level: input register, scanner core, result register.
// Depends on ics_pkg and ics_core.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one source byte per
//   transaction; in_data.last_char marks the final byte of a text. Only that
//   final byte produces a transaction on the output channel (out_valid,
//   out_stall, out_data), giving complete and reason_code.
//   Throughput is one byte per cycle while no last byte waits for room in the
//   result register: the scanner state updates once per byte through flag
//   logic and saturating counters. out_valid rises once the last byte has
//   passed the input register, then the result register.
//   Reset (rst, synchronous) clears the pipeline valids and all scanner
//   state. After each last byte the scanner state returns to reset values.
//   When out_stall holds a result, bytes that give no result still flow
//   through; a last byte waits in the input register, and in_stall is high
//   while it waits, until the result is taken.
`default_nettype none

module input_completeness_scanner
  import ics_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_free;
  logic      s1_move;
  out_item_t core_result;

  // Stage advance: a last byte needs room in the result register
  assign out_free = ~out_valid | ~out_stall;
  assign s1_move  = s1_valid & (~s1_item.last_char | out_free);
  assign in_stall = s1_valid & ~s1_move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  ics_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_move),
    .item   (s1_item),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_item.last_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_item.last_char) begin
      out_data <= core_result;
    end
  end

endmodule

`default_nettype wire
